### rtl/core/rcf_pkg.sv
`default_nettype none

package rcf_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE   = 3;

   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int EFF_W_W = $clog2(MAX_WIDTH + 1);
   localparam int EFF_H_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 3);

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic                    MODE_SMOOTH  = 1'b0;
   localparam logic                    MODE_SHARPEN = 1'b1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   localparam int CHANNELS   = 3;
   localparam int CHANNEL_W  = 8;
   localparam int PIXEL_W    = CHANNELS * CHANNEL_W;
   localparam int ROW_PAIR_W = 2 * PIXEL_W;
   localparam int WIN_N      = 3;
   localparam int PIXEL_MAX  = 255;

   // Kernel weights. The sharpening neighbours weigh -1, so the sum becomes
   // (centre + 1) * c - total; smoothing neighbours weigh 1.
   localparam int SMOOTH_CENTRE = 4;
   localparam int SHARP_CENTRE  = 20;
   localparam int SMOOTH_GAIN   = SMOOTH_CENTRE - 1;
   localparam int SHARP_GAIN    = SHARP_CENTRE + 1;

   // Division by 12 is a shift by two and a multiplication by the
   // reciprocal of three.
   localparam int QUOT_SHIFT  = 2;
   localparam int RECIP_MULT  = 683;
   localparam int RECIP_SHIFT = 11;

   localparam int TOTAL_W = $clog2(WIN_N * WIN_N * PIXEL_MAX + 1);
   localparam int ACC_W   = $clog2(SHARP_GAIN * PIXEL_MAX + 1);
   localparam int Q_W     = ACC_W - QUOT_SHIFT;
   localparam int RECIP_W = $clog2(RECIP_MULT + 1);
   localparam int PROD_W  = Q_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - RECIP_SHIFT;

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [WIN_N-1:0][WIN_N-1:0] window_type;

   typedef struct packed {
      window_type win;
      logic       border;
      logic       last;
   } win_word_type;

endpackage

`default_nettype wire

### rtl/core/rcf_ram.sv
`default_nettype none

module rcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/rcf_window.sv
`default_nettype none

module rcf_window
   import rcf_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [WIDTH_REG_W-1:0]  image_width,
   input  wire logic [HEIGHT_REG_W-1:0] image_height,
   input  wire logic                    in_valid,
   output      logic                    in_ready,
   input  wire logic                    in_action,
   input  wire logic [PIXEL_W-1:0]      in_pixel,
   output      logic                    win_valid,
   input  wire logic                    win_ready,
   output      win_word_type            win_word
);

   logic [EFF_W_W-1:0] w_eff;
   logic [EFF_H_W-1:0] h_eff;
   logic [COL_W-1:0]   w_last;
   logic [ROW_W-1:0]   h_last;

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_in;

   logic             col_wrap;
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [COL_W-1:0] centre_col;
   logic [ROW_W-1:0] centre_row;
   logic             emit;
   logic             row_end;
   logic             col_end;
   logic             border;
   logic             in_accept;

   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   pixel_type        s1_pix_ff;
   logic             s1_emit_ff;
   logic             s1_border_ff;
   logic             s1_last_ff;
   logic             s1_fwd_ff;
   logic             s1_go;

   logic [ROW_PAIR_W-1:0] ram_rd_data;
   logic [ROW_PAIR_W-1:0] row_data;
   logic [ROW_PAIR_W-1:0] wr_data;
   logic [ROW_PAIR_W-1:0] fwd_data_ff;

   window_type win_ff;
   window_type win_next;

   always_comb begin
      if (image_width < WIDTH_REG_W'(MIN_SIZE)) begin
         w_eff = EFF_W_W'(MIN_SIZE);
      end else if (32'(image_width) > MAX_WIDTH) begin
         w_eff = EFF_W_W'(MAX_WIDTH);
      end else begin
         w_eff = EFF_W_W'(image_width);
      end
      if (image_height < HEIGHT_REG_W'(MIN_SIZE)) begin
         h_eff = EFF_H_W'(MIN_SIZE);
      end else if (32'(image_height) > MAX_HEIGHT) begin
         h_eff = EFF_H_W'(MAX_HEIGHT);
      end else begin
         h_eff = EFF_H_W'(image_height);
      end
   end

   assign w_last = COL_W'(w_eff - EFF_W_W'(1));
   assign h_last = ROW_W'(h_eff) - ROW_W'(1);

   // A column left beyond the width by a smaller width starts a new row.
   assign col_wrap = EFF_W_W'(col_ff) >= w_eff;
   assign cur_col  = col_wrap ? '0 : col_ff;
   assign cur_row  = col_wrap ? row_ff + ROW_W'(1) : row_ff;

   always_comb begin
      if (cur_col != '0) begin
         centre_row = cur_row - ROW_W'(1);
         centre_col = cur_col - COL_W'(1);
      end else begin
         centre_row = cur_row - ROW_W'(2);
         centre_col = w_last;
      end
      emit = ((cur_row >= ROW_W'(2)) || (cur_row == ROW_W'(1) && cur_col != '0))
             && (centre_row <= h_last);
      row_end = centre_row == h_last;
      col_end = centre_col == w_last;
      border  = (centre_row == '0) || row_end || (centre_col == '0) || col_end;

      if (cur_row >= ROW_W'(h_eff) + ROW_W'(1)) begin
         col_in = '0;
         row_in = '0;
      end else if (EFF_W_W'(cur_col) + EFF_W_W'(1) >= w_eff) begin
         col_in = '0;
         row_in = cur_row + ROW_W'(1);
      end else begin
         col_in = cur_col + COL_W'(1);
         row_in = cur_row;
      end
   end

   assign s1_go     = s1_valid_ff && (!s1_emit_ff || win_ready);
   assign in_ready  = !s1_valid_ff || s1_go;
   assign in_accept = in_valid && in_ready;

   // The word that left in the cycle of the read has not reached the memory.
   assign row_data = s1_fwd_ff ? fwd_data_ff : ram_rd_data;
   assign wr_data  = {row_data[PIXEL_W-1:0], s1_pix_ff};

   always_comb begin
      for (int i = 0; i < WIN_N; i++) begin
         for (int j = 0; j < WIN_N - 1; j++) begin
            win_next[i][j] = win_ff[i][j+1];
         end
      end
      win_next[0][WIN_N-1] = row_data[ROW_PAIR_W-1:PIXEL_W];
      win_next[1][WIN_N-1] = row_data[PIXEL_W-1:0];
      win_next[2][WIN_N-1] = s1_pix_ff;
   end

   rcf_ram #(
      .WIDTH(ROW_PAIR_W),
      .DEPTH(MAX_WIDTH)
   ) u_row_ram (
      .clock  (clock),
      .wr_en  (s1_go),
      .wr_addr(s1_col_ff),
      .wr_data(wr_data),
      .rd_en  (in_accept),
      .rd_addr(cur_col),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (in_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (s1_go) begin
            win_ff <= win_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_col_ff    <= cur_col;
         s1_pix_ff    <= in_action ? '0 : in_pixel;
         s1_emit_ff   <= emit;
         s1_border_ff <= border;
         s1_last_ff   <= row_end && col_end;
         s1_fwd_ff    <= s1_go && (s1_col_ff == cur_col);
      end
      if (s1_go) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign win_valid       = s1_valid_ff && s1_emit_ff;
   assign win_word.win    = win_next;
   assign win_word.border = s1_border_ff;
   assign win_word.last   = s1_last_ff;

endmodule

`default_nettype wire

### rtl/core/rcf_kernel.sv
`default_nettype none

module rcf_kernel
   import rcf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             filter_mode,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire win_word_type     in_word,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      logic [PIXEL_W-1:0] pixel_out,
   output      logic             frame_last
);

   logic         s2_valid_ff;
   win_word_type s2_word_ff;

   logic                              s3_valid_ff;
   logic [CHANNELS-1:0][TOTAL_W-1:0]  s3_total_ff;
   pixel_type                         s3_centre_ff;
   logic                              s3_border_ff;
   logic                              s3_last_ff;

   logic                          s4_valid_ff;
   logic [CHANNELS-1:0][Q_W-1:0]  s4_q_ff;
   logic [CHANNELS-1:0]           s4_neg_ff;
   pixel_type                     s4_centre_ff;
   logic                          s4_border_ff;
   logic                          s4_last_ff;

   logic      out_valid_ff;
   pixel_type pixel_out_ff;
   logic      frame_last_ff;

   logic out_free;
   logic s4_free;
   logic s3_free;
   logic s2_free;

   logic [CHANNELS-1:0][TOTAL_W-1:0]   total_sum;
   logic [CHANNELS-1:0][ACC_W-1:0]     sharp_gain;
   logic [CHANNELS-1:0][ACC_W-1:0]     smooth_gain;
   logic [CHANNELS-1:0][ACC_W-1:0]     acc_mag;
   logic [CHANNELS-1:0]                acc_neg;
   logic [CHANNELS-1:0][PROD_W-1:0]    prod;
   logic [CHANNELS-1:0][QUOT_W-1:0]    quot;
   pixel_type                          filtered;

   assign out_free = !out_valid_ff || out_ready;
   assign s4_free  = !s4_valid_ff || out_free;
   assign s3_free  = !s3_valid_ff || s4_free;
   assign s2_free  = !s2_valid_ff || s3_free;
   assign in_ready = s2_free;

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         total_sum[ch] = '0;
         for (int i = 0; i < WIN_N; i++) begin
            for (int j = 0; j < WIN_N; j++) begin
               total_sum[ch] = total_sum[ch]
                  + TOTAL_W'(s2_word_ff.win[i][j][ch*CHANNEL_W +: CHANNEL_W]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sharp_gain[ch]  = ACC_W'(s3_centre_ff[ch*CHANNEL_W +: CHANNEL_W])
                           * ACC_W'(SHARP_GAIN);
         smooth_gain[ch] = ACC_W'(s3_centre_ff[ch*CHANNEL_W +: CHANNEL_W])
                           * ACC_W'(SMOOTH_GAIN);
         if (filter_mode == MODE_SHARPEN) begin
            acc_neg[ch] = ACC_W'(s3_total_ff[ch]) > sharp_gain[ch];
            acc_mag[ch] = sharp_gain[ch] - ACC_W'(s3_total_ff[ch]);
         end else begin
            acc_neg[ch] = 1'b0;
            acc_mag[ch] = ACC_W'(s3_total_ff[ch]) + smooth_gain[ch];
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         prod[ch] = PROD_W'(s4_q_ff[ch]) * PROD_W'(RECIP_MULT);
         quot[ch] = prod[ch][PROD_W-1:RECIP_SHIFT];
         if (s4_neg_ff[ch]) begin
            filtered[ch*CHANNEL_W +: CHANNEL_W] = '0;
         end else if (quot[ch] > QUOT_W'(PIXEL_MAX)) begin
            filtered[ch*CHANNEL_W +: CHANNEL_W] = CHANNEL_W'(PIXEL_MAX);
         end else begin
            filtered[ch*CHANNEL_W +: CHANNEL_W] = quot[ch][CHANNEL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_free) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_word_ff <= in_word;
      end
      if (s3_free) begin
         s3_total_ff  <= total_sum;
         s3_centre_ff <= s2_word_ff.win[1][1];
         s3_border_ff <= s2_word_ff.border;
         s3_last_ff   <= s2_word_ff.last;
      end
      if (s4_free) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            s4_q_ff[ch] <= acc_mag[ch][ACC_W-1:QUOT_SHIFT];
         end
         s4_neg_ff    <= acc_neg;
         s4_centre_ff <= s3_centre_ff;
         s4_border_ff <= s3_border_ff;
         s4_last_ff   <= s3_last_ff;
      end
      if (out_free) begin
         pixel_out_ff  <= s4_border_ff ? s4_centre_ff : filtered;
         frame_last_ff <= s4_last_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign pixel_out  = pixel_out_ff;
   assign frame_last = frame_last_ff;

endmodule

`default_nettype wire

### rtl/core/rgb_3x3_convolution_filter.sv
// Throughput: one word per cycle while rsp_ready does not hold back the output, set by the row
// memory, which is read once and written once for every word, back to back.
// Pipeline: the input word that completes a window, the word image_width+1 positions after its
// centre, passes the row stage, the kernel stages s2, s3 and s4 and the output register.
// Reset clears the position counters, the window, the pipeline and the registers
// (smoothing, 640 by 480); the row memory is not cleared and needs no time after reset.
`default_nettype none

module rgb_3x3_convolution_filter
   import rcf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic                   req_action,
   input  wire logic [PIXEL_W-1:0]     req_pixel_in,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [PIXEL_W-1:0]     rsp_pixel_out,
   output      logic                   rsp_frame_last,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   logic                    filter_mode_ff;
   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic                    filter_mode_in;
   logic [WIDTH_REG_W-1:0]  image_width_in;
   logic [HEIGHT_REG_W-1:0] image_height_in;

   logic         win_valid;
   logic         win_ready;
   win_word_type win_word;

   assign csr_ready = 1'b1;

   always_comb begin
      filter_mode_in  = filter_mode_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FILTER_MODE: begin
               filter_mode_in = csr_data[0];
            end
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_data[WIDTH_REG_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_data[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= MODE_SMOOTH;
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
      end else begin
         filter_mode_ff  <= filter_mode_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   rcf_window u_window (
      .clock       (clock),
      .reset       (reset),
      .image_width (image_width_ff),
      .image_height(image_height_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_action   (req_action),
      .in_pixel    (req_pixel_in),
      .win_valid   (win_valid),
      .win_ready   (win_ready),
      .win_word    (win_word)
   );

   rcf_kernel u_kernel (
      .clock      (clock),
      .reset      (reset),
      .filter_mode(filter_mode_ff),
      .in_valid   (win_valid),
      .in_ready   (win_ready),
      .in_word    (win_word),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .pixel_out  (rsp_pixel_out),
      .frame_last (rsp_frame_last)
   );

   // After reset the pipeline is empty and open for input.
   assert property (@(posedge clock) $past(reset) |-> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   // With the output register empty, no stage may hold back the input.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled while the output is empty");

   // A window leaving the row stage while the kernel is full would be lost.
   assert property (@(posedge clock) disable iff (reset)
      (win_valid && !win_ready) |=> win_valid)
      else $error("window word dropped under back-pressure");

endmodule

`default_nettype wire
